FILE: rtl/core/mbist_pkg.sv
package mbist_pkg;

  // Configuration defaults and reset values
  localparam int unsigned ADDR_BITS_DEF     = 18;
  localparam int unsigned MAX_DATA_BITS_DEF = 8;
  localparam int unsigned MEM_DEPTH_RST     = 65536;
  localparam int unsigned DATA_BITS_RST     = 1;
  localparam logic        TEST_MODE_RST     = 1'b1;

  // March element bookkeeping
  localparam int unsigned ELEM_W    = 3;
  localparam int unsigned OPIDX_W   = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [ELEM_W-1:0] LAST_ELEM = 3'd4;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_kind_e;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } operation_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MEM_DEPTH = 2'd0,
    CFG_DATA_BITS = 2'd1,
    CFG_TEST_MODE = 2'd2
  } cfg_index_e;

  // Operation encoding: bit 1 = read, bit 0 = data value
  localparam logic [1:0] MOP_W0 = 2'b00;
  localparam logic [1:0] MOP_W1 = 2'b01;
  localparam logic [1:0] MOP_R0 = 2'b10;
  localparam logic [1:0] MOP_R1 = 2'b11;

  function automatic logic [OPIDX_W-1:0] elem_len(input logic [ELEM_W-1:0] elem);
    logic [OPIDX_W-1:0] len;
    unique case (elem)
      3'd0:    len = 3'd1;
      3'd1:    len = 3'd6;
      3'd2:    len = 3'd3;
      3'd3:    len = 3'd4;
      3'd4:    len = 3'd3;
      default: len = 3'd1;
    endcase
    return len;
  endfunction

  function automatic logic elem_down(input logic [ELEM_W-1:0] elem);
    return (elem == 3'd3) || (elem == 3'd4);
  endfunction

  // M0 w0 | M1 r0 w1 r1 w0 r0 w1 | M2 r1 w0 w1 | M3 r1 w0 w1 w0 | M4 r0 w1 w0
  function automatic logic [1:0] op_code(input logic [ELEM_W-1:0]  elem,
                                         input logic [OPIDX_W-1:0] idx);
    logic [1:0] code;
    code = MOP_W0;
    unique case (elem)
      3'd1: begin
        case (idx)
          3'd0:    code = MOP_R0;
          3'd1:    code = MOP_W1;
          3'd2:    code = MOP_R1;
          3'd3:    code = MOP_W0;
          3'd4:    code = MOP_R0;
          3'd5:    code = MOP_W1;
          default: code = MOP_W0;
        endcase
      end
      3'd2, 3'd3: begin
        case (idx)
          3'd0:    code = MOP_R1;
          3'd2:    code = MOP_W1;
          default: code = MOP_W0;
        endcase
      end
      3'd4: begin
        case (idx)
          3'd0:    code = MOP_R0;
          3'd1:    code = MOP_W1;
          default: code = MOP_W0;
        endcase
      end
      default: code = MOP_W0;
    endcase
    return code;
  endfunction

endpackage

FILE: rtl/core/mbist_if.sv
interface mbist_item_if #(
  parameter int unsigned DataW = mbist_pkg::MAX_DATA_BITS_DEF
);
  logic             valid;
  logic             ready;
  logic             operation;
  logic [DataW-1:0] read_data;

  modport source (output valid, output operation, output read_data, input ready);
  modport sink   (input valid, input operation, input read_data, output ready);
endinterface

interface mbist_result_if #(
  parameter int unsigned AddrW = mbist_pkg::ADDR_BITS_DEF,
  parameter int unsigned DataW = mbist_pkg::MAX_DATA_BITS_DEF,
  parameter int unsigned BitW  = 3
);
  logic                        valid;
  logic                        ready;
  logic [1:0]                  cmd_kind;
  logic [AddrW-1:0]            cmd_addr;
  logic [DataW-1:0]            cmd_wdata;
  logic                        finished;
  logic [DataW-1:0]            fail_mask;
  logic [mbist_pkg::ELEM_W-1:0] element_index;
  logic [BitW-1:0]             bit_index;

  modport source (output valid, output cmd_kind, output cmd_addr, output cmd_wdata,
                  output finished, output fail_mask, output element_index,
                  output bit_index, input ready);
  modport sink   (input valid, input cmd_kind, input cmd_addr, input cmd_wdata,
                  input finished, input fail_mask, input element_index,
                  input bit_index, output ready);
endinterface

interface mbist_cfg_if #(
  parameter int unsigned CfgW = 19
);
  logic                               valid;
  logic                               ready;
  logic [mbist_pkg::CFG_IDX_W-1:0]    index;
  logic [CfgW-1:0]                    wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

FILE: rtl/core/mbist_cfg.sv
module mbist_cfg #(
  parameter int unsigned ADDR_BITS     = mbist_pkg::ADDR_BITS_DEF,
  parameter int unsigned MAX_DATA_BITS = mbist_pkg::MAX_DATA_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  mbist_cfg_if.sink                            cfg_i,
  output logic [ADDR_BITS:0]                   eff_depth_o,
  output logic [$clog2(MAX_DATA_BITS+1)-1:0]   eff_bits_o,
  output logic                                 test_mode_o
);
  localparam int unsigned DepthW = ADDR_BITS + 1;
  localparam int unsigned DbW    = $clog2(MAX_DATA_BITS + 1);

  logic [DepthW-1:0] depth_q, depth_d;
  logic [DbW-1:0]    bits_q, bits_d;
  logic              mode_q, mode_d;
  logic              wr_en;

  assign cfg_i.ready = 1'b1;
  assign wr_en       = cfg_i.valid && cfg_i.ready;

  always_comb begin
    depth_d = depth_q;
    bits_d  = bits_q;
    mode_d  = mode_q;
    if (wr_en) begin
      unique case (cfg_i.index)
        mbist_pkg::CFG_MEM_DEPTH: depth_d = cfg_i.wdata[DepthW-1:0];
        mbist_pkg::CFG_DATA_BITS: bits_d  = cfg_i.wdata[DbW-1:0];
        mbist_pkg::CFG_TEST_MODE: mode_d  = cfg_i.wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= DepthW'(mbist_pkg::MEM_DEPTH_RST);
      bits_q  <= DbW'(mbist_pkg::DATA_BITS_RST);
      mode_q  <= mbist_pkg::TEST_MODE_RST;
    end else begin
      depth_q <= depth_d;
      bits_q  <= bits_d;
      mode_q  <= mode_d;
    end
  end

  // Zero means one; clamp to what the address and data widths can reach
  always_comb begin
    if (depth_q == '0) begin
      eff_depth_o = DepthW'(1);
    end else if (depth_q > (DepthW'(1) << ADDR_BITS)) begin
      eff_depth_o = DepthW'(1) << ADDR_BITS;
    end else begin
      eff_depth_o = depth_q;
    end
    if (bits_q == '0) begin
      eff_bits_o = DbW'(1);
    end else if (bits_q > DbW'(MAX_DATA_BITS)) begin
      eff_bits_o = DbW'(MAX_DATA_BITS);
    end else begin
      eff_bits_o = bits_q;
    end
  end

  assign test_mode_o = mode_q;

endmodule

FILE: rtl/core/mbist_core.sv
module mbist_core #(
  parameter int unsigned ADDR_BITS     = mbist_pkg::ADDR_BITS_DEF,
  parameter int unsigned MAX_DATA_BITS = mbist_pkg::MAX_DATA_BITS_DEF,
  parameter int unsigned BitW          = 3
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                step_en_i,
  input  logic                                operation_i,
  input  logic [MAX_DATA_BITS-1:0]            read_data_i,
  input  logic [ADDR_BITS:0]                  eff_depth_i,
  input  logic [$clog2(MAX_DATA_BITS+1)-1:0]  eff_bits_i,
  input  logic                                test_mode_i,
  output logic [1:0]                          cmd_kind_o,
  output logic [ADDR_BITS-1:0]                cmd_addr_o,
  output logic [MAX_DATA_BITS-1:0]            cmd_wdata_o,
  output logic                                finished_o,
  output logic [MAX_DATA_BITS-1:0]            fail_mask_o,
  output logic [mbist_pkg::ELEM_W-1:0]        element_index_o,
  output logic [BitW-1:0]                     bit_index_o
);
  localparam int unsigned ElemW  = mbist_pkg::ELEM_W;
  localparam int unsigned OpW    = mbist_pkg::OPIDX_W;
  localparam int unsigned DepthW = ADDR_BITS + 1;
  localparam int unsigned CmpW   = $clog2(MAX_DATA_BITS + 1) + 1;

  logic [ElemW-1:0]         elem_q, elem_d;
  logic [OpW-1:0]           opi_q, opi_d;
  logic [ADDR_BITS-1:0]     addr_q, addr_d;
  logic [BitW-1:0]          bit_q, bit_d;
  logic [MAX_DATA_BITS-1:0] fail_q, fail_d;
  logic                     pend_q, pend_d;
  logic                     exp_q, exp_d;
  logic                     run_q, run_d;
  logic                     done_q, done_d;

  logic [1:0]               code;
  logic [MAX_DATA_BITS-1:0] mask;
  logic                     issue;
  logic [ElemW-1:0]         iss_elem;
  logic [BitW-1:0]          iss_bit;
  logic                     last_bit;
  logic                     up_more;

  always_comb begin
    elem_d = elem_q;
    opi_d  = opi_q;
    addr_d = addr_q;
    bit_d  = bit_q;
    fail_d = fail_q;
    pend_d = pend_q;
    exp_d  = exp_q;
    run_d  = run_q;
    done_d = done_q;
    code   = mbist_pkg::MOP_W0;
    mask   = '0;
    issue  = 1'b0;
    iss_elem = elem_q;
    iss_bit  = bit_q;
    last_bit = 1'b0;
    up_more  = 1'b0;
    cmd_kind_o  = mbist_pkg::CMD_NONE;
    cmd_addr_o  = '0;
    cmd_wdata_o = '0;

    if (operation_i == mbist_pkg::OP_START) begin
      elem_d = '0;
      opi_d  = '0;
      addr_d = '0;
      bit_d  = '0;
      fail_d = '0;
      pend_d = 1'b0;
      exp_d  = 1'b0;
      run_d  = 1'b1;
      done_d = 1'b0;
    end else begin
      // Check the read; on mismatch go to the next bit or end the run
      if (run_q && pend_q) begin
        pend_d = 1'b0;
        if (read_data_i[bit_q] != exp_q) begin
          fail_d   = fail_q | (MAX_DATA_BITS'(1) << bit_q);
          last_bit = (CmpW'(bit_q) + CmpW'(1)) >= CmpW'(eff_bits_i);
          elem_d   = '0;
          opi_d    = '0;
          addr_d   = '0;
          if (last_bit) begin
            run_d  = 1'b0;
            done_d = 1'b1;
          end else begin
            bit_d  = bit_q + BitW'(1);
          end
        end
      end

      if (run_d) begin
        issue    = 1'b1;
        code     = mbist_pkg::op_code(elem_d, opi_d);
        mask     = MAX_DATA_BITS'(1) << bit_d;
        iss_elem = elem_d;
        iss_bit  = bit_d;
        cmd_addr_o = addr_d;
        if (code[1]) begin
          cmd_kind_o = mbist_pkg::CMD_READ;
          pend_d     = 1'b1;
          exp_d      = code[0];
        end else begin
          cmd_kind_o  = mbist_pkg::CMD_WRITE;
          cmd_wdata_o = code[0] ? mask : ~mask;
        end

        // Advance op, then address, then element, then bit
        up_more = (DepthW'(addr_d) + DepthW'(1)) < eff_depth_i;
        if ((opi_d + OpW'(1)) < mbist_pkg::elem_len(elem_d)) begin
          opi_d = opi_d + OpW'(1);
        end else begin
          opi_d = '0;
          if (mbist_pkg::elem_down(elem_d) && (addr_d != '0)) begin
            addr_d = addr_d - ADDR_BITS'(1);
          end else if (!mbist_pkg::elem_down(elem_d) && up_more) begin
            addr_d = addr_d + ADDR_BITS'(1);
          end else if ((elem_d == '0) && !test_mode_i) begin
            run_d  = 1'b0;
            done_d = 1'b1;
            elem_d = '0;
            addr_d = '0;
          end else if (elem_d >= mbist_pkg::LAST_ELEM) begin
            last_bit = (CmpW'(bit_d) + CmpW'(1)) >= CmpW'(eff_bits_i);
            elem_d   = '0;
            addr_d   = '0;
            if (last_bit) begin
              run_d  = 1'b0;
              done_d = 1'b1;
            end else begin
              bit_d  = bit_d + BitW'(1);
            end
          end else begin
            elem_d = elem_d + ElemW'(1);
            addr_d = mbist_pkg::elem_down(elem_d) ?
                     ADDR_BITS'(eff_depth_i - DepthW'(1)) : '0;
          end
        end
      end
    end

    finished_o      = done_d;
    fail_mask_o     = fail_d;
    element_index_o = issue ? iss_elem : elem_d;
    bit_index_o     = issue ? iss_bit : bit_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_q <= '0;
      opi_q  <= '0;
      addr_q <= '0;
      bit_q  <= '0;
      fail_q <= '0;
      pend_q <= 1'b0;
      exp_q  <= 1'b0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else if (step_en_i) begin
      elem_q <= elem_d;
      opi_q  <= opi_d;
      addr_q <= addr_d;
      bit_q  <= bit_d;
      fail_q <= fail_d;
      pend_q <= pend_d;
      exp_q  <= exp_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  a_run_done_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(run_q && done_q))
    else $error("running and done both set");

  a_pend_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> run_q)
    else $error("read pending outside a run");

  a_op_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (elem_q <= mbist_pkg::LAST_ELEM) && (opi_q < mbist_pkg::elem_len(elem_q)))
    else $error("march position out of range");

  a_fail_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_en_i && (operation_i == mbist_pkg::OP_STEP))
      |=> ((fail_q & $past(fail_q)) == $past(fail_q)))
    else $error("fail flag cleared without a start");

endmodule

FILE: rtl/core/march_b_memory_test_sequencer.sv
// A transaction passes the input register, then the result register, to
// result_o. Throughput: one transaction per cycle while result_o.ready is
// high; as separate stages, a new item enters while a result waits.
// The per-item work is a single combinational pass over the march state.
// Reset (rst_ni low, asynchronous): both stages empty, run idle, fail flags
// clear, registers at depth 65536, one data bit, full March B.
module march_b_memory_test_sequencer #(
  parameter int unsigned ADDR_BITS     = mbist_pkg::ADDR_BITS_DEF,
  parameter int unsigned MAX_DATA_BITS = mbist_pkg::MAX_DATA_BITS_DEF,
  parameter int unsigned BitW          = (MAX_DATA_BITS > 1) ? $clog2(MAX_DATA_BITS) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  mbist_cfg_if.sink     cfg_i,
  mbist_item_if.sink    item_i,
  mbist_result_if.source result_o
);
  localparam int unsigned DbW = $clog2(MAX_DATA_BITS + 1);

  // Configuration registers, clamped to usable values
  logic [ADDR_BITS:0] eff_depth;
  logic [DbW-1:0]     eff_bits;
  logic               test_mode;

  mbist_cfg #(
    .ADDR_BITS     (ADDR_BITS),
    .MAX_DATA_BITS (MAX_DATA_BITS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_i),
    .eff_depth_o (eff_depth),
    .eff_bits_o  (eff_bits),
    .test_mode_o (test_mode)
  );

  // Input stage: holds one transaction until the result register can take it
  logic                     s1_valid_q, s1_valid_d;
  logic                     s1_op_q;
  logic [MAX_DATA_BITS-1:0] s1_rdata_q;
  logic                     out_free;
  logic                     s1_fire;
  logic                     in_fire;

  // Result register
  logic                        out_valid_q, out_valid_d;
  logic [1:0]                  kind_q, kind_d;
  logic [ADDR_BITS-1:0]        addr_q, addr_d;
  logic [MAX_DATA_BITS-1:0]    wdata_q, wdata_d;
  logic                        fin_q, fin_d;
  logic [MAX_DATA_BITS-1:0]    fmask_q, fmask_d;
  logic [mbist_pkg::ELEM_W-1:0] elem_q, elem_d;
  logic [BitW-1:0]             bidx_q, bidx_d;

  assign out_free     = !out_valid_q || result_o.ready;
  assign s1_fire      = s1_valid_q && out_free;
  assign item_i.ready = !s1_valid_q || out_free;
  assign in_fire      = item_i.valid && item_i.ready;

  assign s1_valid_d  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);
  assign out_valid_d = s1_fire ? 1'b1 : (result_o.ready ? 1'b0 : out_valid_q);

  // March state advances only when a stage-1 transaction moves into the
  // result register, so each step is processed exactly once.
  mbist_core #(
    .ADDR_BITS     (ADDR_BITS),
    .MAX_DATA_BITS (MAX_DATA_BITS),
    .BitW          (BitW)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_en_i       (s1_fire),
    .operation_i     (s1_op_q),
    .read_data_i     (s1_rdata_q),
    .eff_depth_i     (eff_depth),
    .eff_bits_i      (eff_bits),
    .test_mode_i     (test_mode),
    .cmd_kind_o      (kind_d),
    .cmd_addr_o      (addr_d),
    .cmd_wdata_o     (wdata_d),
    .finished_o      (fin_d),
    .fail_mask_o     (fmask_d),
    .element_index_o (elem_d),
    .bit_index_o     (bidx_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q    <= item_i.operation;
      s1_rdata_q <= item_i.read_data;
    end
    if (s1_fire) begin
      kind_q  <= kind_d;
      addr_q  <= addr_d;
      wdata_q <= wdata_d;
      fin_q   <= fin_d;
      fmask_q <= fmask_d;
      elem_q  <= elem_d;
      bidx_q  <= bidx_d;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.cmd_kind      = kind_q;
  assign result_o.cmd_addr      = addr_q;
  assign result_o.cmd_wdata     = wdata_q;
  assign result_o.finished      = fin_q;
  assign result_o.fail_mask     = fmask_q;
  assign result_o.element_index = elem_q;
  assign result_o.bit_index     = bidx_q;

endmodule

FILE: tb/sv/march_b_sb_pkg.sv
`timescale 1ns / 100ps

package march_b_sb_pkg;
  import mbist_pkg::*;

  typedef struct packed {
    cmd_kind_e   cmd_kind;
    logic [17:0] cmd_addr;
    logic [7:0]  cmd_wdata;
    logic        finished;
    logic [7:0]  fail_mask;
    logic [2:0]  element_index;
    logic [2:0]  bit_index;
  } march_cmd_t;

  class march_b_scoreboard;
    // register copies
    logic [18:0] depth_reg;
    logic [3:0]  bits_reg;
    logic        mode_reg;
    // march state
    int unsigned elem, op_idx, addr, bit_no;
    logic [7:0]  fail_flags;
    bit          rd_pend, rd_val, running, done;
    march_cmd_t  cmd_q[$];
    // bookkeeping
    int          errors;
    int unsigned n_reads, n_writes, n_runs, n_bit_fails, max_addr;

    function new();
      depth_reg   = MEM_DEPTH_RST;
      bits_reg    = DATA_BITS_RST;
      mode_reg    = TEST_MODE_RST;
      clear_run();
      running     = 0;
      done        = 0;
      errors      = 0;
      n_reads     = 0;
      n_writes    = 0;
      n_runs      = 0;
      n_bit_fails = 0;
      max_addr    = 0;
    endfunction

    function void clear_run();
      elem       = 0;
      op_idx     = 0;
      addr       = 0;
      bit_no     = 0;
      fail_flags = '0;
      rd_pend    = 0;
      rd_val     = 0;
    endfunction

    function void set_reg(cfg_index_e idx, logic [18:0] val);
      case (idx)
        CFG_MEM_DEPTH: depth_reg = val;
        CFG_DATA_BITS: bits_reg = val[3:0];
        CFG_TEST_MODE: mode_reg = val[0];
        default: ;
      endcase
    endfunction

    function int unsigned depth_now();
      int unsigned d;
      d = depth_reg;
      if (d == 0) d = 1;
      if (d > (1 << 18)) d = 1 << 18;
      return d;
    endfunction

    function int unsigned bits_now();
      int unsigned b;
      b = bits_reg;
      if (b == 0) b = 1;
      if (b > 8) b = 8;
      return b;
    endfunction

    // {is_read, value} for op idx of element el
    function logic [1:0] march_op(int unsigned el, int unsigned idx);
      logic [1:0] seq [6];
      case (el)
        1: seq = '{MOP_R0, MOP_W1, MOP_R1, MOP_W0, MOP_R0, MOP_W1};
        2: seq = '{MOP_R1, MOP_W0, MOP_W1, MOP_W0, MOP_W0, MOP_W0};
        3: seq = '{MOP_R1, MOP_W0, MOP_W1, MOP_W0, MOP_W0, MOP_W0};
        4: seq = '{MOP_R0, MOP_W1, MOP_W0, MOP_W0, MOP_W0, MOP_W0};
        default: seq = '{MOP_W0, MOP_W0, MOP_W0, MOP_W0, MOP_W0, MOP_W0};
      endcase
      return seq[idx];
    endfunction

    function int unsigned march_len(int unsigned el);
      int unsigned lens [5];
      lens = '{1, 6, 3, 4, 3};
      return lens[el];
    endfunction

    function void end_run();
      running = 0;
      done    = 1;
      elem    = 0;
      op_idx  = 0;
      addr    = 0;
      n_runs++;
    endfunction

    function void next_bit();
      if (bit_no + 1 >= bits_now()) begin
        end_run();
        return;
      end
      bit_no++;
      elem   = 0;
      op_idx = 0;
      addr   = 0;
    endfunction

    function void advance();
      op_idx++;
      if (op_idx < march_len(elem)) return;
      op_idx = 0;
      if (elem >= 3) begin
        if (addr != 0) begin
          addr--;
          return;
        end
      end else if (addr + 1 < depth_now()) begin
        addr++;
        return;
      end
      if (elem == 0 && !mode_reg) begin
        end_run();
      end else if (elem >= 4) begin
        next_bit();
      end else begin
        elem++;
        addr = (elem >= 3) ? depth_now() - 1 : 0;
      end
    endfunction

    // read data for the next step: tested bit matches unless bad is set
    function logic [7:0] read_byte(bit bad);
      logic [7:0] b;
      b = 8'($urandom);
      if (running && rd_pend) b[bit_no] = rd_val ^ bad;
      return b;
    endfunction

    // returns 1 when the transaction did something (not an ignored step)
    function bit apply_item(operation_e op, logic [7:0] rd);
      march_cmd_t c;
      logic [1:0] mop;
      bit         acted;
      c = '0;
      c.cmd_kind = CMD_NONE;
      acted = 1;
      if (op == OP_START) begin
        clear_run();
        running = 1;
        done    = 0;
      end else begin
        acted = running;
        if (running && rd_pend) begin
          rd_pend = 0;
          if (rd[bit_no] != rd_val) begin
            fail_flags[bit_no] = 1'b1;
            n_bit_fails++;
            next_bit();
          end
        end
        if (running) begin
          mop = march_op(elem, op_idx);
          c.cmd_addr      = addr[17:0];
          c.element_index = elem[2:0];
          c.bit_index     = bit_no[2:0];
          if (addr > max_addr) max_addr = addr;
          if (mop[1]) begin
            c.cmd_kind = CMD_READ;
            rd_pend    = 1;
            rd_val     = mop[0];
            n_reads++;
          end else begin
            c.cmd_kind  = CMD_WRITE;
            c.cmd_wdata = mop[0] ? (8'h01 << bit_no) : ~(8'h01 << bit_no);
            n_writes++;
          end
          advance();
          c.finished  = done;
          c.fail_mask = fail_flags;
          cmd_q.push_back(c);
          return acted;
        end
      end
      c.finished      = done;
      c.fail_mask     = fail_flags;
      c.element_index = elem[2:0];
      c.bit_index     = bit_no[2:0];
      cmd_q.push_back(c);
      return acted;
    endfunction

    function void check_cmd(march_cmd_t got);
      march_cmd_t want;
      if (cmd_q.size() == 0) begin
        $error("result with no command outstanding");
        errors++;
        return;
      end
      want = cmd_q.pop_front();
      if (got.cmd_kind !== want.cmd_kind) begin
        $error("cmd_kind: expected %0d, got %0d", want.cmd_kind, got.cmd_kind);
        errors++;
      end
      if (got.cmd_addr !== want.cmd_addr) begin
        $error("cmd_addr: expected %0d, got %0d", want.cmd_addr, got.cmd_addr);
        errors++;
      end
      if (got.cmd_wdata !== want.cmd_wdata) begin
        $error("cmd_wdata: expected %02h, got %02h", want.cmd_wdata, got.cmd_wdata);
        errors++;
      end
      if (got.finished !== want.finished) begin
        $error("finished: expected %0d, got %0d", want.finished, got.finished);
        errors++;
      end
      if (got.fail_mask !== want.fail_mask) begin
        $error("fail_mask: expected %02h, got %02h", want.fail_mask, got.fail_mask);
        errors++;
      end
      if (got.element_index !== want.element_index) begin
        $error("element_index: expected %0d, got %0d", want.element_index,
               got.element_index);
        errors++;
      end
      if (got.bit_index !== want.bit_index) begin
        $error("bit_index: expected %0d, got %0d", want.bit_index, got.bit_index);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return cmd_q.size();
    endfunction
  endclass

endpackage

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import mbist_pkg::*;
  import march_b_sb_pkg::*;

  localparam int unsigned ITEM_TARGET    = 1900;
  localparam int unsigned PHASE_MAX      = 300;  // caps a phase when depth is large
  localparam int unsigned WATCHDOG_LIMIT = 3000; // cycles without any transaction
  localparam int unsigned DRAIN_CYCLES   = 4;    // covers the two-stage latency

  // receiver back-pressure styles
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PERIODIC,
    RX_SPARSE
  } rx_style_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #6 clk_i = ~clk_i;

  mbist_cfg_if    cfg_bus ();
  mbist_item_if   item_bus ();
  mbist_result_if res_bus ();

  march_b_memory_test_sequencer dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_bus),
    .item_i  (item_bus),
    .result_o(res_bus)
  );

  march_b_scoreboard sb = new();

  int unsigned n_items   = 0; // transactions that did something
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned rx_cycle  = 0;
  rx_style_e   rx_style  = RX_ALWAYS;

  // Receiver: ready follows a randomly reshuffled style, so long stretches
  // of full throughput alternate with heavy stalling.
  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 256 == 0) rx_style <= rx_style_e'($urandom_range(0, 3));
    case (rx_style)
      RX_ALWAYS:   res_bus.ready <= 1'b1;
      RX_RANDOM:   res_bus.ready <= ($urandom_range(0, 9) < 7);
      RX_PERIODIC: res_bus.ready <= ((rx_cycle % 7) > 1);
      default:     res_bus.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Result monitor: every accepted result transaction goes to the scoreboard.
  always @(posedge clk_i) begin : result_mon
    march_cmd_t seen;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      seen.cmd_kind      = cmd_kind_e'(res_bus.cmd_kind);
      seen.cmd_addr      = res_bus.cmd_addr;
      seen.cmd_wdata     = res_bus.cmd_wdata;
      seen.finished      = res_bus.finished;
      seen.fail_mask     = res_bus.fail_mask;
      seen.element_index = res_bus.element_index;
      seen.bit_index     = res_bus.bit_index;
      sb.check_cmd(seen);
    end
  end

  // Watchdog: any transaction on any channel counts as progress.
  always @(posedge clk_i) begin
    if ((item_bus.valid && item_bus.ready) || (res_bus.valid && res_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Drive one item transaction. The sender runs in bursts; between bursts
  // valid drops for a random gap (sometimes none, giving back-to-back bursts).
  task automatic send(input operation_e op, input logic [7:0] rd);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        item_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    item_bus.valid     <= 1'b1;
    item_bus.operation <= op;
    item_bus.read_data <= rd;
    do @(posedge clk_i); while (!(item_bus.valid && item_bus.ready));
    if (sb.apply_item(op, rd)) n_items++;
  endtask

  // Step with read data that passes, or fails on the tested bit.
  task automatic step(input bit bad);
    send(OP_STEP, sb.read_byte(bad));
  endtask

  // Stop sending and let every outstanding result drain out.
  task automatic wait_idle();
    item_bus.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One register write; valid stays up so back-to-back writes need no gap.
  task automatic write_reg(input cfg_index_e idx, input logic [18:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.wdata <= val;
    do @(posedge clk_i); while (!(cfg_bus.valid && cfg_bus.ready));
    sb.set_reg(idx, val);
  endtask

  // Reprogram all three registers with the block idle. Unused upper bits of
  // the narrow registers carry junk, which must be ignored.
  task automatic program_regs(input logic [18:0] depth, input logic [3:0] nbits,
                              input logic mode);
    wait_idle();
    write_reg(CFG_MEM_DEPTH, depth);
    write_reg(CFG_DATA_BITS, {15'($urandom), nbits});
    write_reg(CFG_TEST_MODE, {18'($urandom), mode});
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [18:0] depth;
    logic [3:0]  nbits;
    logic        mode;
    int unsigned err_pct;
    int unsigned phase_items;

    rst_ni             <= 1'b0;
    item_bus.valid     <= 1'b0;
    item_bus.operation <= OP_STEP;
    item_bus.read_data <= '0;
    cfg_bus.valid      <= 1'b0;
    cfg_bus.index      <= CFG_MEM_DEPTH;
    cfg_bus.wdata      <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed ----
    // Step before any start: idle, no command.
    send(OP_STEP, 8'hFF);

    // Warm-up with depth zero and zero data bits (both act as one):
    // a single w0, then the run is over.
    program_regs(19'd0, 4'd0, 1'b0);
    send(OP_START, 8'h00);
    send(OP_STEP, 8'h00);
    send(OP_STEP, 8'hFF);

    // Two bits, depth one: bit 0 fails on its first read, bit 1 too, and the
    // failure of the last bit ends the run.
    program_regs(19'd1, 4'd2, 1'b1);
    send(OP_START, 8'hFF);
    send(OP_STEP, 8'h00);   // w0
    send(OP_STEP, 8'h00);   // r0
    send(OP_STEP, 8'hFF);   // bit 0 reads 1 -> fail, bit 1 starts
    send(OP_STEP, 8'h00);   // r0 of bit 1
    send(OP_STEP, 8'hFF);   // bit 1 fails, run finished
    send(OP_STEP, 8'h00);   // after finish: nothing

    // Depth one, data bits above the maximum. Walk into M3, then raise the
    // depth past the address range mid-run: M4 starts at the top address.
    program_regs(19'd1, 4'd15, 1'b1);
    send(OP_START, 8'h00);
    repeat (11) step(1'b0);
    wait_idle();
    write_reg(CFG_MEM_DEPTH, 19'h7FFFF);
    cfg_bus.valid <= 1'b0;
    repeat (5) step(1'b0);
    send(OP_START, 8'h00);  // restart in the middle of a run

    // ---- random phases ----
    // Mostly small memories so runs complete and every bit gets marched;
    // now and then a huge depth, reconfiguration without restart, read
    // errors at varying rates and stray transactions.
    while (n_items < ITEM_TARGET) begin
      case ($urandom_range(0, 19))
        0:       depth = 19'd0;
        1:       depth = 19'h40000;
        2:       depth = 19'h7FFFF;
        3:       depth = 19'($urandom_range(7, 262143));
        default: depth = 19'($urandom_range(1, 6));
      endcase
      nbits = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15)) :
                                            4'($urandom_range(1, 8));
      mode  = ($urandom_range(0, 6) != 0);
      program_regs(depth, nbits, mode);

      if (!sb.running || $urandom_range(0, 3) != 0) send(OP_START, 8'($urandom));

      case ($urandom_range(0, 2))
        0:       err_pct = 0;
        1:       err_pct = 2;
        default: err_pct = 12;
      endcase

      phase_items = 0;
      while (sb.running && phase_items < PHASE_MAX && n_items < ITEM_TARGET) begin
        if ($urandom_range(0, 199) == 0) begin
          send(operation_e'($urandom_range(0, 1)), 8'($urandom));
        end else begin
          step($urandom_range(0, 99) < err_pct);
        end
        phase_items++;
      end
      // steps after the end of a run must leave everything unchanged
      if (!sb.running) repeat ($urandom_range(0, 2)) send(OP_STEP, 8'($urandom));
    end

    // ---- drain and report ----
    wait_idle();
    repeat (8) @(posedge clk_i);
    if (sb.pending() != 0) sb.errors++;

    $display("Ran %0d transactions: %0d reads, %0d writes issued, %0d runs completed",
             n_items, sb.n_reads, sb.n_writes, sb.n_runs);
    $display("Flagged %0d failing bits, highest address reached %0d",
             sb.n_bit_fails, sb.max_addr);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
